// File: rtl/dmap_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmap_pkg: shared types and tables for the Diameter AVP parser
// Event codes, parser phases, lookup functions and the front/back queue entry.
// ----------------------------------------------------------------------------
package dmap_pkg;

	localparam int unsigned QueueDepth = 4;

	typedef enum logic [1:0] {
		EV_HEADER = 2'd0,
		EV_VALUE  = 2'd1,
		EV_EMPTY  = 2'd2,
		EV_ERROR  = 2'd3
	} event_kind_t;

	typedef enum logic [6:0] {
		PH_HDR    = 7'b0000001,
		PH_AVP    = 7'b0000010,
		PH_VENDOR = 7'b0000100,
		PH_VALUE  = 7'b0001000,
		PH_PAD    = 7'b0010000,
		PH_SKIP   = 7'b0100000,
		PH_HALT   = 7'b1000000
	} phase_t;

	localparam logic [2:0] TagNone = 3'd7;

	// One classified event from the front part.
	typedef struct packed {
		event_kind_t kind;
		logic [23:0] command_code;
		logic        request_flag;
		logic [31:0] application_id;
		logic [2:0]  avp_field;
		logic [7:0]  value_byte;
		logic        value_last;
	} evt_t;

	function automatic logic [2:0] tag_of(input logic [31:0] code);
		logic [2:0] t;
		case (code)
			32'd1:   t = 3'd0;
			32'd263: t = 3'd1;
			32'd264: t = 3'd2;
			32'd283: t = 3'd3;
			32'd293: t = 3'd4;
			32'd296: t = 3'd5;
			default: t = TagNone;
		endcase
		return t;
	endfunction

	function automatic logic [4:0] cmd_index(input logic [23:0] c);
		logic [4:0] r;
		case (c)
			24'd257: r = 5'd1;
			24'd258: r = 5'd2;
			24'd271: r = 5'd3;
			24'd272: r = 5'd4;
			24'd274: r = 5'd5;
			24'd275: r = 5'd6;
			24'd280: r = 5'd7;
			24'd282: r = 5'd8;
			default: begin
				if (c >= 24'd300 && c <= 24'd309)
					r = 5'(c - 24'd291);
				else if (c >= 24'd316 && c <= 24'd323)
					r = 5'(c - 24'd297);
				else
					r = 5'd0;
			end
		endcase
		return r;
	endfunction

	function automatic logic [4:0] app_index(input logic [31:0] a);
		logic [4:0] r;
		case (a)
			32'hffffffff: r = 5'd11;
			32'd16777216: r = 5'd12;
			32'd16777217: r = 5'd13;
			32'd16777236: r = 5'd14;
			32'd16777238: r = 5'd15;
			32'd16777251: r = 5'd16;
			32'd16777252: r = 5'd17;
			32'd16777255: r = 5'd18;
			32'd16777265: r = 5'd19;
			32'd16777272: r = 5'd20;
			32'd16777291: r = 5'd21;
			default: begin
				if (a <= 32'd9)
					r = 5'(a + 32'd1);
				else
					r = 5'd0;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/dmap_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmap_front: byte-level deframer
// Walks message headers and AVPs one byte per transfer and pushes events.
// ----------------------------------------------------------------------------
module dmap_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    data_byte,
	input  wire logic          stream_start,
	input  wire logic          take,
	output logic               push,
	output dmap_pkg::evt_t     push_evt
);

	dmap_pkg::phase_t phase_q, ph_d;
	logic [4:0]  pos_q, pos_d;
	logic [23:0] mrem_q, mrem_d;
	logic [7:0]  hflags_q, hflags_d;
	logic [23:0] hcmd_q, hcmd_d;
	logic [31:0] happ_q, happ_d;
	logic [31:0] acode_q, acode_d;
	logic [7:0]  aflags_q, aflags_d;
	logic [23:0] alen_q, alen_d;
	logic [23:0] vrem_q, vrem_d;
	logic [1:0]  prem_q, prem_d;
	logic [2:0]  tag_q, tag_d;
	logic        tail;
	logic [23:0] alen_n, rest, vlen;
	logic        vflag;

	always_comb begin
		ph_d = phase_q; pos_d = pos_q; mrem_d = mrem_q;
		hflags_d = hflags_q; hcmd_d = hcmd_q; happ_d = happ_q;
		acode_d = acode_q; aflags_d = aflags_q; alen_d = alen_q;
		vrem_d = vrem_q; prem_d = prem_q; tag_d = tag_q;
		push = 1'b0;
		push_evt = '0;
		tail = 1'b0;
		alen_n = '0; rest = '0; vlen = '0; vflag = 1'b0;
		if (stream_start) begin
			ph_d = dmap_pkg::PH_HDR; pos_d = '0; mrem_d = '0;
			hflags_d = '0; hcmd_d = '0; happ_d = '0;
			acode_d = '0; aflags_d = '0; alen_d = '0;
			vrem_d = '0; prem_d = '0; tag_d = '0;
		end
		case (ph_d)
			dmap_pkg::PH_HDR: begin
				pos_d = pos_d + 5'd1;
				if (pos_d == 5'd1) begin
					mrem_d = '0;
					if (data_byte != 8'd1) begin
						ph_d = dmap_pkg::PH_HALT;
						push = 1'b1;
						push_evt.kind = dmap_pkg::EV_ERROR;
					end
				end else if (pos_d <= 5'd4) begin
					mrem_d = {mrem_d[15:0], data_byte};
					if (pos_d == 5'd4 && mrem_d < 24'd20) begin
						ph_d = dmap_pkg::PH_HALT;
						push = 1'b1;
						push_evt.kind = dmap_pkg::EV_ERROR;
					end
				end else if (pos_d == 5'd5) begin
					hflags_d = data_byte;
				end else if (pos_d <= 5'd8) begin
					hcmd_d = {hcmd_d[15:0], data_byte};
				end else if (pos_d <= 5'd12) begin
					happ_d = {happ_d[23:0], data_byte};
				end else if (pos_d == 5'd20) begin
					mrem_d = mrem_d - 24'd20;
					pos_d = '0;
					ph_d = (mrem_d != '0) ? dmap_pkg::PH_AVP : dmap_pkg::PH_HDR;
					push = 1'b1;
					push_evt.kind = dmap_pkg::EV_HEADER;
				end
			end
			dmap_pkg::PH_AVP: begin
				tail = 1'b1;
				if (pos_d == '0 && mrem_d < 24'd8) begin
					ph_d = dmap_pkg::PH_SKIP;
				end else begin
					if (pos_d <= 5'd3) acode_d = {acode_d[23:0], data_byte};
					else if (pos_d == 5'd4) aflags_d = data_byte;
					else alen_d = {alen_d[15:0], data_byte};
					if (pos_d >= 5'd7) begin
						alen_n = alen_d;
						rest = mrem_d - 24'd1;
						vflag = aflags_d[7];
						vlen = alen_n - 24'd8;
						pos_d = '0;
						if (alen_n < 24'd8 || (vflag && alen_n < 24'd12) || rest < vlen) begin
							ph_d = dmap_pkg::PH_SKIP;
						end else begin
							vrem_d = vflag ? alen_n - 24'd12 : vlen;
							prem_d = 2'd0 - alen_n[1:0];
							tag_d = dmap_pkg::tag_of(acode_d);
							if (vflag) ph_d = dmap_pkg::PH_VENDOR;
							else if (vrem_d != '0) ph_d = dmap_pkg::PH_VALUE;
							else begin
								ph_d = (prem_d != '0) ? dmap_pkg::PH_PAD : dmap_pkg::PH_AVP;
								if (tag_d != dmap_pkg::TagNone) begin
									push = 1'b1;
									push_evt.kind = dmap_pkg::EV_EMPTY;
									push_evt.avp_field = tag_d;
									push_evt.value_last = 1'b1;
								end
							end
						end
					end else begin
						pos_d = pos_d + 5'd1;
					end
				end
			end
			dmap_pkg::PH_VENDOR: begin
				tail = 1'b1;
				pos_d = pos_d + 5'd1;
				if (pos_d >= 5'd4) begin
					pos_d = '0;
					if (vrem_d != '0) ph_d = dmap_pkg::PH_VALUE;
					else begin
						ph_d = (prem_d != '0) ? dmap_pkg::PH_PAD : dmap_pkg::PH_AVP;
						if (tag_d != dmap_pkg::TagNone) begin
							push = 1'b1;
							push_evt.kind = dmap_pkg::EV_EMPTY;
							push_evt.avp_field = tag_d;
							push_evt.value_last = 1'b1;
						end
					end
				end
			end
			dmap_pkg::PH_VALUE: begin
				tail = 1'b1;
				vrem_d = vrem_d - 24'd1;
				if (tag_d != dmap_pkg::TagNone) begin
					push = 1'b1;
					push_evt.kind = dmap_pkg::EV_VALUE;
					push_evt.avp_field = tag_d;
					push_evt.value_byte = data_byte;
					push_evt.value_last = (vrem_d == '0);
				end
				if (vrem_d == '0) begin
					pos_d = '0;
					ph_d = (prem_d != '0) ? dmap_pkg::PH_PAD : dmap_pkg::PH_AVP;
				end
			end
			dmap_pkg::PH_PAD: begin
				tail = 1'b1;
				prem_d = prem_d - 2'd1;
				if (prem_d == '0) begin
					ph_d = dmap_pkg::PH_AVP;
					pos_d = '0;
				end
			end
			dmap_pkg::PH_SKIP: tail = 1'b1;
			default: ;
		endcase
		// message end wins over any AVP state
		if (tail) begin
			if (mrem_d != '0) mrem_d = mrem_d - 24'd1;
			if (mrem_d == '0) begin
				ph_d = dmap_pkg::PH_HDR;
				pos_d = '0;
			end
		end
		if (push && push_evt.kind != dmap_pkg::EV_ERROR) begin
			push_evt.command_code = hcmd_d;
			push_evt.request_flag = hflags_d[7];
			push_evt.application_id = happ_d;
		end
		if (!take) push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dmap_pkg::PH_HDR; pos_q <= '0; mrem_q <= '0;
			hflags_q <= '0; hcmd_q <= '0; happ_q <= '0;
			acode_q <= '0; aflags_q <= '0; alen_q <= '0;
			vrem_q <= '0; prem_q <= '0; tag_q <= '0;
		end else if (take) begin
			phase_q <= ph_d; pos_q <= pos_d; mrem_q <= mrem_d;
			hflags_q <= hflags_d; hcmd_q <= hcmd_d; happ_q <= happ_d;
			acode_q <= acode_d; aflags_q <= aflags_d; alen_q <= alen_d;
			vrem_q <= vrem_d; prem_q <= prem_d; tag_q <= tag_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/dmap_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmap_back: event queue and output stage
// Buffers events, looks up command and application indices, drives results.
// ----------------------------------------------------------------------------
module dmap_back #(
	parameter int unsigned Depth = dmap_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  dmap_pkg::evt_t     push_evt,
	output logic               room,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [1:0]         event_kind,
	output logic [23:0]        command_code,
	output logic               request_flag,
	output logic [4:0]         command_index,
	output logic [31:0]        application_id,
	output logic [4:0]         application_index,
	output logic [2:0]         avp_field,
	output logic [7:0]         value_byte,
	output logic               value_last
);

	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

	dmap_pkg::evt_t mem_q [Depth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0]   cnt_q;
	logic          pop, ovalid_q;
	dmap_pkg::evt_t oevt_q;
	logic [4:0]    cidx_q, aidx_q;

	assign room = (cnt_q < (Aw+1)'(Depth));
	assign pop  = (cnt_q != '0) && (!ovalid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_evt;
		if (pop) begin
			oevt_q <= mem_q[rp_q];
			cidx_q <= (mem_q[rp_q].kind == dmap_pkg::EV_ERROR) ? 5'd0
				: dmap_pkg::cmd_index(mem_q[rp_q].command_code);
			aidx_q <= (mem_q[rp_q].kind == dmap_pkg::EV_ERROR) ? 5'd0
				: dmap_pkg::app_index(mem_q[rp_q].application_id);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; ovalid_q <= 1'b0;
		end else begin
			if (push) wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
			if (pop) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
		end
	end

	assign out_valid         = ovalid_q;
	assign event_kind        = oevt_q.kind;
	assign command_code      = oevt_q.command_code;
	assign request_flag      = oevt_q.request_flag;
	assign command_index     = cidx_q;
	assign application_id    = oevt_q.application_id;
	assign application_index = aidx_q;
	assign avp_field         = oevt_q.avp_field;
	assign value_byte        = oevt_q.value_byte;
	assign value_last        = oevt_q.value_last;

endmodule
`default_nettype wire

// File: rtl/diameter_message_avp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diameter_message_avp_parser: Diameter header and AVP deframer
// Channel | signals                                   | direction
// in      | in_valid, in_stall, data_byte, stream_start | byte stream in
// out     | out_valid, out_stall, event fields        | events out
// One byte per cycle while in_stall is low; up to one event per byte.
// An event is written into the queue, then into the output register.
// arst_n clears the parser to the header phase and empties the queue.
// in_stall rises only when the event queue is full; out_stall holds the
// output register and lets the queue absorb up to QueueDepth events.
// ----------------------------------------------------------------------------
module diameter_message_avp_parser #(
	parameter int unsigned QueueDepth = dmap_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        stream_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       event_kind,
	output logic [23:0]      command_code,
	output logic             request_flag,
	output logic [4:0]       command_index,
	output logic [31:0]      application_id,
	output logic [4:0]       application_index,
	output logic [2:0]       avp_field,
	output logic [7:0]       value_byte,
	output logic             value_last
);

	logic room, take, push;
	dmap_pkg::evt_t push_evt;

	assign in_stall = !room;
	assign take = in_valid && room;

	dmap_front u_front (
		.clk, .arst_n, .data_byte, .stream_start, .take, .push, .push_evt
	);

	dmap_back #(.Depth(QueueDepth)) u_back (
		.clk, .arst_n, .push, .push_evt, .room, .out_valid, .out_stall,
		.event_kind, .command_code, .request_flag, .command_index,
		.application_id, .application_index, .avp_field, .value_byte, .value_last
	);

endmodule
`default_nettype wire

// File: rtl/dmap_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmap_checker: port-level checks
// Handshake and event-field consistency on the top level ports.
// ----------------------------------------------------------------------------
module dmap_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  event_kind,
	input wire logic [23:0] command_code,
	input wire logic [7:0]  value_byte,
	input wire logic        value_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(value_byte))
		else $error("stalled transfer changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == dmap_pkg::EV_ERROR |-> command_code == '0 && !value_last)
		else $error("error event carries fields");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == dmap_pkg::EV_EMPTY |-> value_last && value_byte == '0)
		else $error("empty value event malformed");

	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == dmap_pkg::EV_HEADER |-> !value_last)
		else $error("header event with last mark");

endmodule

bind diameter_message_avp_parser dmap_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .event_kind, .command_code, .value_byte, .value_last
);
`default_nettype wire
